FILE: rtl/core/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and codes for the lowest seed point core
// Request op codes, register indexes, border slot codes and the job and
// register bundles passed between the front, queue and back end.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned NumSlots = 9;

   // request op codes
   localparam logic OP_POINT = 1'b0;
   localparam logic OP_CLOSE = 1'b1;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_BORDER_POSITION = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_EXPAND_TO_BORDER = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CELL_LOW_X = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_CELL_HIGH_X = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_CELL_LOW_Y = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_CELL_HIGH_Y = 3'd5;

   // border_position bits
   localparam int unsigned POS_BOTTOM = 0;
   localparam int unsigned POS_TOP = 1;
   localparam int unsigned POS_LEFT = 2;
   localparam int unsigned POS_RIGHT = 3;

   // emission slots, in output order
   localparam logic [NumSlots-1:0] SEL_BASE = 9'b000000001;
   localparam logic [NumSlots-1:0] SEL_TOP = 9'b000000010;
   localparam logic [NumSlots-1:0] SEL_TOP_LEFT = 9'b000000100;
   localparam logic [NumSlots-1:0] SEL_TOP_RIGHT = 9'b000001000;
   localparam logic [NumSlots-1:0] SEL_BOT = 9'b000010000;
   localparam logic [NumSlots-1:0] SEL_BOT_LEFT = 9'b000100000;
   localparam logic [NumSlots-1:0] SEL_BOT_RIGHT = 9'b001000000;
   localparam logic [NumSlots-1:0] SEL_LEFT = 9'b010000000;
   localparam logic [NumSlots-1:0] SEL_RIGHT = 9'b100000000;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
   } job_type;

   typedef struct packed {
      logic [3:0]                   border_position;
      logic                         expand_to_border;
      logic signed [CoordWidth-1:0] cell_low_x;
      logic signed [CoordWidth-1:0] cell_high_x;
      logic signed [CoordWidth-1:0] cell_low_y;
      logic signed [CoordWidth-1:0] cell_high_y;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

FILE: rtl/core/lsp_front.sv
// ----------------------------------------------------------------------------
// lsp_front: request front end
// Tracks the lowest point of the open cell and queues it as a job on close.
// ----------------------------------------------------------------------------
module lsp_front
   import lsp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic signed [CoordWidth-1:0] req_point_x,
   input  logic signed [CoordWidth-1:0] req_point_y,
   input  logic signed [CoordWidth-1:0] req_point_z,
   input  q_status_type                 q_status,
   output logic                         push,
   output job_type                      push_job
);

   logic    have_ff, have_in;
   job_type best_ff, best_in;
   logic    accept;

   assign req_ready = !q_status.full;
   assign accept = req_valid && req_ready;
   assign push = accept && (req_op == OP_CLOSE) && have_ff;
   assign push_job = best_ff;

   always_comb begin
      have_in = have_ff;
      best_in = best_ff;
      if (accept) begin
         if (req_op == OP_CLOSE) begin
            have_in = 1'b0;
         end else if (!have_ff || (req_point_z < best_ff.z)) begin
            have_in = 1'b1;
            best_in.x = req_point_x;
            best_in.y = req_point_y;
            best_in.z = req_point_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      best_ff <= best_in;
   end

endmodule

FILE: rtl/core/lsp_queue.sv
// ----------------------------------------------------------------------------
// lsp_queue: two-entry job queue
// Decouples the front end from the emission sequencer.
// ----------------------------------------------------------------------------
module lsp_queue
   import lsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head,
   output q_status_type status
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("job queue underflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("job queue count out of range");

endmodule

FILE: rtl/core/lsp_back.sv
// ----------------------------------------------------------------------------
// lsp_back: emission sequencer
// Walks the head job's enabled slots, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module lsp_back
   import lsp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  q_status_type                 q_status,
   input  job_type                      head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [CoordWidth-1:0] rsp_out_x,
   output logic signed [CoordWidth-1:0] rsp_out_y,
   output logic signed [CoordWidth-1:0] rsp_out_z,
   output logic                         rsp_last_of_cell
);

   logic                         active_ff, active_in;
   logic [NumSlots-1:0]          rem_ff, rem_in;
   logic                         valid_ff, valid_in;
   logic signed [CoordWidth-1:0] x_ff, x_in;
   logic signed [CoordWidth-1:0] y_ff, y_in;
   logic signed [CoordWidth-1:0] z_ff;
   logic                         last_ff;
   logic [NumSlots-1:0]          full_mask;
   logic [NumSlots-1:0]          cur_rem;
   logic [NumSlots-1:0]          pick;
   logic [NumSlots-1:0]          new_rem;
   logic                         load;
   logic                         e, top, bot, lft, rgt;

   assign rsp_valid = valid_ff;
   assign rsp_out_x = x_ff;
   assign rsp_out_y = y_ff;
   assign rsp_out_z = z_ff;
   assign rsp_last_of_cell = last_ff;

   always_comb begin
      e = cfg.expand_to_border;
      top = cfg.border_position[POS_TOP];
      bot = cfg.border_position[POS_BOTTOM];
      lft = cfg.border_position[POS_LEFT];
      rgt = cfg.border_position[POS_RIGHT];
      full_mask = SEL_BASE
                | ({NumSlots{e & top}} & SEL_TOP)
                | ({NumSlots{e & top & lft}} & SEL_TOP_LEFT)
                | ({NumSlots{e & top & rgt}} & SEL_TOP_RIGHT)
                | ({NumSlots{e & bot}} & SEL_BOT)
                | ({NumSlots{e & bot & lft}} & SEL_BOT_LEFT)
                | ({NumSlots{e & bot & rgt}} & SEL_BOT_RIGHT)
                | ({NumSlots{e & lft}} & SEL_LEFT)
                | ({NumSlots{e & rgt}} & SEL_RIGHT);
      cur_rem = active_ff ? rem_ff : full_mask;
      pick = cur_rem & (~cur_rem + {{(NumSlots-1){1'b0}}, 1'b1});
      new_rem = cur_rem & ~pick;
      load = !q_status.empty && (!valid_ff || rsp_ready);
      pop = load && (new_rem == '0);

      case (pick)
         SEL_TOP: begin
            x_in = head.x;
            y_in = cfg.cell_high_y;
         end
         SEL_TOP_LEFT: begin
            x_in = cfg.cell_low_x;
            y_in = cfg.cell_high_y;
         end
         SEL_TOP_RIGHT: begin
            x_in = cfg.cell_high_x;
            y_in = cfg.cell_high_y;
         end
         SEL_BOT: begin
            x_in = head.x;
            y_in = cfg.cell_low_y;
         end
         SEL_BOT_LEFT: begin
            x_in = cfg.cell_low_x;
            y_in = cfg.cell_low_y;
         end
         SEL_BOT_RIGHT: begin
            x_in = cfg.cell_high_x;
            y_in = cfg.cell_low_y;
         end
         SEL_LEFT: begin
            x_in = cfg.cell_low_x;
            y_in = head.y;
         end
         SEL_RIGHT: begin
            x_in = cfg.cell_high_x;
            y_in = head.y;
         end
         default: begin
            x_in = head.x;
            y_in = head.y;
         end
      endcase

      valid_in = valid_ff;
      active_in = active_ff;
      rem_in = rem_ff;
      if (load) begin
         valid_in = 1'b1;
         active_in = (new_rem != '0);
         rem_in = new_rem;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         active_ff <= 1'b0;
         rem_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         active_ff <= active_in;
         rem_ff <= rem_in;
      end
      if (load) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= head.z;
         last_ff <= (new_rem == '0);
      end
   end

endmodule

FILE: rtl/core/lowest_seed_point_with_border_copies_core.sv
// ----------------------------------------------------------------------------
// lowest_seed_point_with_border_copies_core: lowest seed point of a grid cell
// Keeps the strictly lowest point of a cell and, on close, emits it with
// optional copies moved to the cell box edges.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  op, point_x, point_y, point_z
//  rsp_      out        rsp_valid / rsp_ready  out_x, out_y, out_z, last_of_cell
//  csr_      in         csr_we                 csr_index, csr_wdata
//
//  Point requests are taken one per cycle while the job queue is not full.
//  A close with a point queues one job; the back end then emits 1 to 9
//  results for it from its slot sequencer, one per cycle unless the output stalls.
//  The front stalls only when both entries of the two-job queue are full.
//  Synchronous active-high reset clears control state and the registers.
//  A stalled result holds in the output register while requests go on.
//
module lowest_seed_point_with_border_copies_core
   import lsp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic signed [CoordWidth-1:0] req_point_x,
   input  logic signed [CoordWidth-1:0] req_point_y,
   input  logic signed [CoordWidth-1:0] req_point_z,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [CoordWidth-1:0] rsp_out_x,
   output logic signed [CoordWidth-1:0] rsp_out_y,
   output logic signed [CoordWidth-1:0] rsp_out_z,
   output logic                         rsp_last_of_cell,
   // register write port
   input  logic                         csr_we,
   input  logic [CsrIndexWidth-1:0]     csr_index,
   input  logic [CoordWidth-1:0]        csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   logic         push;
   logic         pop;
   job_type      push_job;
   job_type      head;

   // registers: host must write only while nothing is in flight; not enforced
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BORDER_POSITION:  cfg_in.border_position = csr_wdata[3:0];
            CSR_EXPAND_TO_BORDER: cfg_in.expand_to_border = csr_wdata[0];
            CSR_CELL_LOW_X:       cfg_in.cell_low_x = $signed(csr_wdata);
            CSR_CELL_HIGH_X:      cfg_in.cell_high_x = $signed(csr_wdata);
            CSR_CELL_LOW_Y:       cfg_in.cell_low_y = $signed(csr_wdata);
            CSR_CELL_HIGH_Y:      cfg_in.cell_high_y = $signed(csr_wdata);
            default:              cfg_in = cfg_ff;  // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: lowest point tracking
   lsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .q_status    (q_status),
      .push        (push),
      .push_job    (push_job)
   );

   // job queue between the two halves
   lsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // back end: border copy sequencer and output register
   lsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_status         (q_status),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_last_of_cell (rsp_last_of_cell)
   );

endmodule

FILE: verif/lowest_seed_point_with_border_copies_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lowest_seed_point_with_border_copies_core_test: self-checking bench
// Streams grid cells of point requests and closes into the core and checks
// every emitted seed point and border copy against an in-bench tracker of
// the lowest point and the cell box. It runs a directed table, edge box
// settings, an output hold-off that backs the core up, then random phases.
// ----------------------------------------------------------------------------
module lowest_seed_point_with_border_copies_core_test
   import lsp_pkg::*;
();

   localparam int CLOCK_HALF = 5;
   localparam int RESET_CYCLES = 10;
   localparam int SETTLE_CYCLES = 20;      // after the last result, before touching registers
   localparam int HOLD_OFF_CYCLES = 300;   // long output stall, fills the job queue
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake on either channel
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_REQUESTS = 37;
   localparam int PRESSURE_CELLS = 12;

   localparam logic signed [CoordWidth-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [CoordWidth-1:0] COORD_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic                         op;
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
   } request_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
      logic                         last;
   } result_type;

   // one row of the directed table; typed rows carry the result written in
   typedef struct packed {
      request_type request;
      logic        typed;
      result_type  want;
   } table_row_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_op;
   logic signed [CoordWidth-1:0] req_point_x;
   logic signed [CoordWidth-1:0] req_point_y;
   logic signed [CoordWidth-1:0] req_point_z;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [CoordWidth-1:0] rsp_out_x;
   logic signed [CoordWidth-1:0] rsp_out_y;
   logic signed [CoordWidth-1:0] rsp_out_z;
   logic                         rsp_last_of_cell;
   logic                         csr_we;
   logic [CsrIndexWidth-1:0]     csr_index;
   logic [CoordWidth-1:0]        csr_wdata;

   // tracker state: lowest point of the open cell and the register shadow
   logic                         seed_valid = 1'b0;
   logic signed [CoordWidth-1:0] seed_x = '0;
   logic signed [CoordWidth-1:0] seed_y = '0;
   logic signed [CoordWidth-1:0] seed_z = '0;
   cfg_type                      cell_settings = '0;

   result_type    expected_points[$];
   table_row_type directed_table[$];

   // stimulus knobs, partly shared with the output-ready process
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   bit          hold_off_wanted = 1'b0;
   bit          quiet_tail = 1'b0;

   // tallies
   int unsigned requests_sent = 0;
   int unsigned points_seen = 0;
   int unsigned closes_seen = 0;
   int unsigned empty_closes = 0;
   int unsigned results_checked = 0;
   int unsigned settings_applied = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   lowest_seed_point_with_border_copies_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_last_of_cell(rsp_last_of_cell),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Seed point tracker. A point request replaces the held point only if its z
   // is strictly lower, so the earlier point wins a tie. A close with a point
   // queues the base point, then the border copies in slot order: top row
   // (with left/right corners), bottom row (same), left, right. Only the last
   // result of the cell carries last_of_cell. A close on an empty cell yields
   // nothing. Either way the held point is cleared.
   // ---------------------------------------------------------------------------
   function automatic void seed_point_step(input request_type r);
      logic signed [CoordWidth-1:0] cx [NumSlots];
      logic signed [CoordWidth-1:0] cy [NumSlots];
      logic [3:0]                   pos;
      int                           n;
      if (r.op == OP_POINT) begin
         points_seen++;
         if (!seed_valid || r.z < seed_z) begin
            seed_valid = 1'b1;
            seed_x = r.x;
            seed_y = r.y;
            seed_z = r.z;
         end
         return;
      end
      closes_seen++;
      if (!seed_valid) begin
         empty_closes++;
         return;
      end
      pos = cell_settings.border_position;
      cx[0] = seed_x;
      cy[0] = seed_y;
      n = 1;
      if (cell_settings.expand_to_border) begin
         if (pos[POS_TOP]) begin
            cx[n] = seed_x;                    cy[n] = cell_settings.cell_high_y; n++;
            if (pos[POS_LEFT]) begin
               cx[n] = cell_settings.cell_low_x;  cy[n] = cell_settings.cell_high_y; n++;
            end
            if (pos[POS_RIGHT]) begin
               cx[n] = cell_settings.cell_high_x; cy[n] = cell_settings.cell_high_y; n++;
            end
         end
         if (pos[POS_BOTTOM]) begin
            cx[n] = seed_x;                    cy[n] = cell_settings.cell_low_y;  n++;
            if (pos[POS_LEFT]) begin
               cx[n] = cell_settings.cell_low_x;  cy[n] = cell_settings.cell_low_y;  n++;
            end
            if (pos[POS_RIGHT]) begin
               cx[n] = cell_settings.cell_high_x; cy[n] = cell_settings.cell_low_y;  n++;
            end
         end
         if (pos[POS_LEFT]) begin
            cx[n] = cell_settings.cell_low_x;  cy[n] = seed_y; n++;
         end
         if (pos[POS_RIGHT]) begin
            cx[n] = cell_settings.cell_high_x; cy[n] = seed_y; n++;
         end
      end
      for (int i = 0; i < n; i++)
         expected_points.insert(expected_points.size(),
                                result_type'({cx[i], cy[i], seed_z, (i == n - 1)}));
      seed_valid = 1'b0;
      seed_x = '0;
      seed_y = '0;
      seed_z = '0;
   endfunction

   // coordinates lean on the extremes and on a narrow band, so z ties are common
   function automatic logic signed [CoordWidth-1:0] pick_coord();
      int band;
      case ($urandom_range(0, 7)) inside
         0: return COORD_MIN;
         1: return COORD_MAX;
         [2:3]: begin
            band = $urandom_range(0, 8);
            return band - 4;
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      s.border_position = 4'($urandom_range(0, 15));
      s.expand_to_border = ($urandom_range(0, 3) != 0);
      s.cell_low_x = pick_coord();
      s.cell_high_x = pick_coord();
      s.cell_low_y = pick_coord();
      s.cell_high_y = pick_coord();
      return s;
   endfunction

   function automatic void table_point(input logic signed [CoordWidth-1:0] x,
                                       input logic signed [CoordWidth-1:0] y,
                                       input logic signed [CoordWidth-1:0] z);
      directed_table.insert(directed_table.size(),
         table_row_type'({OP_POINT, x, y, z, 1'b0, {(3*CoordWidth+1){1'b0}}}));
   endfunction

   // a close carries junk coordinates, which the core must ignore
   function automatic void table_close(input logic typed,
                                       input logic signed [CoordWidth-1:0] x,
                                       input logic signed [CoordWidth-1:0] y,
                                       input logic signed [CoordWidth-1:0] z);
      logic [CoordWidth-1:0] jx, jy, jz;
      jx = $urandom;
      jy = $urandom;
      jz = $urandom;
      directed_table.insert(directed_table.size(),
         table_row_type'({OP_CLOSE, jx, jy, jz, typed, x, y, z, 1'b1}));
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver. Optional idle gap first, then valid held with a steady
   // payload until the core takes it. The tracker is advanced in the step of
   // the handshake; a typed row swaps the tracker's result for the written one.
   // ---------------------------------------------------------------------------
   task automatic send_request(input request_type r, input logic typed,
                               input result_type want);
      int unsigned gap;
      int          depth;
      gap = 0;
      if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct)
         gap = $urandom_range(1, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= r.op;
      req_point_x <= r.x;
      req_point_y <= r.y;
      req_point_z <= r.z;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      depth = expected_points.size();
      seed_point_step(r);
      if (typed) begin
         while (expected_points.size() > depth)
            expected_points.delete(expected_points.size() - 1);
         expected_points.insert(expected_points.size(), want);
      end
   endtask

   task automatic random_cell();
      int    npts;
      logic [CoordWidth-1:0] jx, jy, jz;
      npts = $urandom_range(0, 5);
      repeat (npts)
         send_request({OP_POINT, pick_coord(), pick_coord(), pick_coord()}, 1'b0, '0);
      jx = $urandom;
      jy = $urandom;
      jz = $urandom;
      send_request({OP_CLOSE, jx, jy, jz}, 1'b0, '0);
   endtask

   // drop valid, let every expected result come out, then let the core settle
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [CoordWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_BORDER_POSITION:  cell_settings.border_position = data[3:0];
         CSR_EXPAND_TO_BORDER: cell_settings.expand_to_border = data[0];
         CSR_CELL_LOW_X:       cell_settings.cell_low_x = data;
         CSR_CELL_HIGH_X:      cell_settings.cell_high_x = data;
         CSR_CELL_LOW_Y:       cell_settings.cell_low_y = data;
         CSR_CELL_HIGH_Y:      cell_settings.cell_high_y = data;
         default: ;
      endcase
   endtask

   // unused upper bits of the narrow registers get random filler
   task automatic apply_settings(input cfg_type s);
      logic [CoordWidth-1:0] w;
      w = $urandom;
      w[3:0] = s.border_position;
      write_register(CSR_BORDER_POSITION, w);
      w = $urandom;
      w[0] = s.expand_to_border;
      write_register(CSR_EXPAND_TO_BORDER, w);
      write_register(CSR_CELL_LOW_X, s.cell_low_x);
      write_register(CSR_CELL_HIGH_X, s.cell_high_x);
      write_register(CSR_CELL_LOW_Y, s.cell_low_y);
      write_register(CSR_CELL_HIGH_Y, s.cell_high_y);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic report_mismatch(input string what, input result_type want,
                                  input result_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: expected x=%0d y=%0d z=%0d last=%0b, got x=%0d y=%0d z=%0d last=%0b",
                  $time, what, want.x, want.y, want.z, want.last,
                  got.x, got.y, got.z, got.last);
   endtask

   // ---------------------------------------------------------------------------
   // Output ready: random stall bursts, one long hold-off on request from the
   // main sequence, and steady ready in the quiet tail.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         if (hold_off_wanted) begin
            hold_off_wanted = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet_tail && receiver_stall_pct != 0 &&
                      $urandom_range(1, 100) <= receiver_stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker and watchdog. Outputs are sampled at the edge, before the
   // core's registers move, so the order of processes within a step is moot.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_x, rsp_out_y, rsp_out_z, rsp_last_of_cell};
            if (expected_points.size() == 0) begin
               report_mismatch("result with nothing pending", '0, got);
            end else begin
               want = expected_points.pop_front();
               results_checked++;
               if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                   got.last !== want.last)
                  report_mismatch("seed point mismatch", want, got);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     quiet_cycles, expected_points.size());
            $display("lowest_seed_point_with_border_copies_core_test NOT OK");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : main_sequence
      cfg_type  edge_settings[3];
      cfg_type  s;
      int       target;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_op      = OP_POINT;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_BORDER_POSITION;
      csr_wdata   = '0;

      // Directed cells under reset settings (no expansion, so one result each).
      table_close(1'b0, '0, '0, '0);                       // empty cell right after reset
      table_point(32'sd0, 32'sd0, 32'sd0);                 // z equal to the cleared value
      table_close(1'b1, 32'sd0, 32'sd0, 32'sd0);
      table_point(COORD_MAX, COORD_MIN, COORD_MAX);
      table_point(COORD_MIN, COORD_MAX, COORD_MIN);
      table_point(32'sd1, 32'sd2, COORD_MIN);               // tie at the floor: earlier stays
      table_close(1'b1, COORD_MIN, COORD_MAX, COORD_MIN);
      table_point(32'sd5, 32'sd6, COORD_MAX);
      table_point(32'sd7, 32'sd8, COORD_MAX);               // tie at the top
      table_close(1'b1, 32'sd5, 32'sd6, COORD_MAX);
      table_point(32'sd10, 32'sd11, -32'sd1);
      table_point(32'sd12, 32'sd13, -32'sd2);
      table_point(32'sd14, 32'sd15, -32'sd2);
      table_point(32'sd16, 32'sd17, 32'sd0);
      table_close(1'b1, 32'sd12, 32'sd13, -32'sd2);
      table_close(1'b0, '0, '0, '0);                       // close straight after a close

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 20;
      receiver_stall_pct = 8;
      foreach (directed_table[i])
         send_request(directed_table[i].request, directed_table[i].typed,
                      directed_table[i].want);
      wait_for_drain();

      // Box edge cases: interior with expansion, full-range box, inverted box.
      edge_settings[0] = '{border_position: 4'd0, expand_to_border: 1'b1,
                           cell_low_x: -32'sd100, cell_high_x: 32'sd100,
                           cell_low_y: -32'sd200, cell_high_y: 32'sd200};
      edge_settings[1] = '{border_position: 4'hF, expand_to_border: 1'b1,
                           cell_low_x: COORD_MIN, cell_high_x: COORD_MAX,
                           cell_low_y: COORD_MIN, cell_high_y: COORD_MAX};
      edge_settings[2] = '{border_position: 4'hF, expand_to_border: 1'b1,
                           cell_low_x: COORD_MAX, cell_high_x: COORD_MIN,
                           cell_low_y: 32'sd4096, cell_high_y: -32'sd4096};
      foreach (edge_settings[i]) begin
         apply_settings(edge_settings[i]);
         send_request({OP_POINT, 32'sd300, -32'sd300, 32'sd1000}, 1'b0, '0);
         send_request({OP_POINT, -32'sd7, 32'sd9, 32'sd999}, 1'b0, '0);
         send_request({OP_CLOSE, COORD_MIN, COORD_MAX, COORD_MIN}, 1'b0, '0);
         wait_for_drain();
      end

      // Back-pressure: nine results per close while the output is held off,
      // so the job queue fills and the request side has to stall.
      s = random_settings();
      s.border_position = 4'hF;
      s.expand_to_border = 1'b1;
      apply_settings(s);
      sender_idle_pct = 0;
      hold_off_wanted = 1'b1;
      repeat (PRESSURE_CELLS) begin
         send_request({OP_POINT, pick_coord(), pick_coord(), pick_coord()}, 1'b0, '0);
         send_request({OP_CLOSE, pick_coord(), pick_coord(), pick_coord()}, 1'b0, '0);
      end
      wait_for_drain();

      // Random phases; the last one runs with no idling on either side.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(random_settings());
         if (phase == RANDOM_PHASES - 1) begin
            quiet_tail = 1'b1;
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: sender_idle_pct = 0;
               1: sender_idle_pct = 10;
               default: sender_idle_pct = 30;
            endcase
            case ($urandom_range(0, 2))
               0: receiver_stall_pct = 0;
               1: receiver_stall_pct = 4;
               default: receiver_stall_pct = 12;
            endcase
         end
         target = requests_sent + PHASE_REQUESTS;
         while (requests_sent < target)
            random_cell();
         wait_for_drain();
      end

      $display("Summary: %0d requests, %0d points, %0d closes (%0d empty), %0d results",
               requests_sent, points_seen, closes_seen, empty_closes, results_checked);
      $display("Summary: %0d box settings incl. inverted and full-range, %0d-cycle hold-off",
               settings_applied, HOLD_OFF_CYCLES);
      if (mismatch_count == 0)
         $display("lowest_seed_point_with_border_copies_core_test OK");
      else
         $display("lowest_seed_point_with_border_copies_core_test NOT OK");
      $finish;
   end

endmodule
